// ===== rtl/scba_pkg.sv =====
// shared types, constants and layout functions of the size-class block allocator
`default_nettype none
package scba_pkg;

  // default configuration of the pool
  localparam int DEF_NUM_CLASSES     = 4;
  localparam int DEF_MIN_BLOCK_ORDER = 4;
  localparam int DEF_REGION_ORDER    = 12;
  localparam int DEF_MIN_COUNT_ORDER = 3;

  // fixed field widths
  localparam int CMD_W    = 1;
  localparam int SIZE_W   = 16;
  localparam int ADDR_W   = 14;
  localparam int STATUS_W = 2;

  // free map row geometry
  localparam int WORD_ORDER = 5;
  localparam int WORD_W     = 1 << WORD_ORDER;

  // request codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOFIT   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BADADDR = 2'd2;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FSET,
    S_EMIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic clear_wr;
    logic take_in;
    logic decode;
    logic scan;
    logic fset;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic cmd_free;
    logic fit_none;
    logic free_bad;
    logic scan_hit;
    logic scan_end;
    logic clear_done;
  } dp_stat_t;

  // log2 of the block count of class c
  function automatic int cls_sh(int c, int mbo, int ro, int mco);
    int raw;
    raw = ro - mbo - c;
    return (raw > mco) ? raw : mco;
  endfunction

  // free map rows taken by class c
  function automatic int cls_rows(int c, int mbo, int ro, int mco);
    int sh;
    sh = cls_sh(c, mbo, ro, mco);
    return (sh >= WORD_ORDER) ? (1 << (sh - WORD_ORDER)) : 1;
  endfunction

  // first free map row of class c
  function automatic int row_base(int c, int mbo, int ro, int mco);
    int acc;
    acc = 0;
    for (int j = 0; j < c; j++) begin
      acc += cls_rows(j, mbo, ro, mco);
    end
    return acc;
  endfunction

  // byte base address of the region of class c
  function automatic int byte_base(int c, int mbo, int ro, int mco);
    int acc;
    acc = 0;
    for (int j = 0; j < c; j++) begin
      acc += 1 << (cls_sh(j, mbo, ro, mco) + mbo + j);
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/scba_ctrl.sv =====
// controller state machine of the size-class block allocator
`default_nettype none
module scba_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire                     out_ready,
  input  wire scba_pkg::dp_stat_t stat,
  output scba_pkg::ctrl_cmd_t     cmd
);
  import scba_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (stat.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (stat.cmd_free) begin
          state_nxt = stat.free_bad ? S_EMIT : S_FSET;
        end else begin
          state_nxt = stat.fit_none ? S_EMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_hit || stat.scan_end) state_nxt = S_EMIT;
      end
      S_FSET: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_CLEAR:  cmd.clear_wr = 1'b1;
      S_IDLE:   cmd.take_in  = in_valid;
      S_DECODE: cmd.decode   = 1'b1;
      S_SCAN:   cmd.scan     = 1'b1;
      S_FSET:   cmd.fset     = 1'b1;
      S_EMIT:   cmd.load_out = !out_valid_r || out_ready;
      default:  cmd = '0;
    endcase
  end

  // output register valid
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/scba_dp.sv =====
// datapath of the size-class block allocator: free map memory, decode and row scan
`default_nettype none
module scba_dp #(
  parameter int NUM_CLASSES     = scba_pkg::DEF_NUM_CLASSES,
  parameter int MIN_BLOCK_ORDER = scba_pkg::DEF_MIN_BLOCK_ORDER,
  parameter int REGION_ORDER    = scba_pkg::DEF_REGION_ORDER,
  parameter int MIN_COUNT_ORDER = scba_pkg::DEF_MIN_COUNT_ORDER
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire  [scba_pkg::CMD_W-1:0]             in_cmd,
  input  wire  [scba_pkg::SIZE_W-1:0]            in_req_size,
  input  wire  [scba_pkg::ADDR_W-1:0]            in_free_addr,
  output logic [scba_pkg::ADDR_W-1:0]            out_block_addr,
  output logic [scba_pkg::STATUS_W-1:0]          out_status,
  input  wire scba_pkg::ctrl_cmd_t               cmd,
  output scba_pkg::dp_stat_t                     stat
);
  import scba_pkg::*;

  localparam int NUM_ROWS = row_base(NUM_CLASSES, MIN_BLOCK_ORDER, REGION_ORDER,
                                     MIN_COUNT_ORDER);
  localparam int RW    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int BIT_W = WORD_ORDER;

  // free map, one bit per block, 1 = free
  logic [WORD_W-1:0] mem [NUM_ROWS];
  logic [WORD_W-1:0] rdata_r;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_we;

  // latched request
  logic [CMD_W-1:0]  cmd_r;
  logic [SIZE_W-1:0] req_r;
  logic [ADDR_W-1:0] faddr_r;

  // scan position
  logic [RW-1:0]    row_r, row_nxt;
  logic [CLS_W-1:0] cls_r, cls_nxt;
  logic [BIT_W-1:0] bit_r;

  // pending result and output register
  logic [ADDR_W-1:0]   res_addr_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [STATUS_W-1:0] out_status_r;

  // decode results
  logic             fit_none;
  logic [CLS_W-1:0] fit_cls;
  logic [RW-1:0]    fit_row;
  logic             free_bad;
  logic [RW-1:0]    free_row;
  logic [BIT_W-1:0] free_bit;

  // scan results
  logic [WORD_W-1:0] cls_mask;
  logic [WORD_W-1:0] masked;
  logic [BIT_W-1:0]  hit_bit;
  logic              scan_hit;
  logic              last_row;
  logic              last_cls;
  logic [31:0]       hit_addr;
  logic              clear_done;

  // smallest class whose block size covers the request
  always_comb begin
    fit_none = 1'b1;
    fit_cls  = '0;
    fit_row  = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if ((32'd1 << (MIN_BLOCK_ORDER + c)) >= {16'd0, req_r}) begin
        fit_none = 1'b0;
        fit_cls  = CLS_W'(c);
        fit_row  = RW'(row_base(c, MIN_BLOCK_ORDER, REGION_ORDER, MIN_COUNT_ORDER));
      end
    end
  end

  // owning region, alignment and map position of a freed address
  always_comb begin
    logic [31:0] addr32;
    logic [31:0] base;
    logic [31:0] span;
    logic [31:0] off;
    logic [31:0] k;
    addr32   = {{(32 - ADDR_W){1'b0}}, faddr_r};
    free_bad = 1'b1;
    free_row = '0;
    free_bit = '0;
    base     = '0;
    span     = '0;
    off      = '0;
    k        = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      base = 32'(byte_base(c, MIN_BLOCK_ORDER, REGION_ORDER, MIN_COUNT_ORDER));
      span = 32'd1 << (cls_sh(c, MIN_BLOCK_ORDER, REGION_ORDER, MIN_COUNT_ORDER)
                       + MIN_BLOCK_ORDER + c);
      if (addr32 >= base && addr32 < base + span) begin
        off = addr32 - base;
        if ((off & ((32'd1 << (MIN_BLOCK_ORDER + c)) - 32'd1)) == 32'd0) begin
          k        = off >> (MIN_BLOCK_ORDER + c);
          free_bad = 1'b0;
          free_row = RW'(32'(row_base(c, MIN_BLOCK_ORDER, REGION_ORDER, MIN_COUNT_ORDER))
                         + (k >> WORD_ORDER));
          free_bit = k[BIT_W-1:0];
        end
      end
    end
  end

  // per-class constants of the class under scan
  always_comb begin
    int sh;
    sh       = 0;
    cls_mask = '0;
    last_row = 1'b0;
    hit_addr = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (cls_r == CLS_W'(c)) begin
        sh       = cls_sh(c, MIN_BLOCK_ORDER, REGION_ORDER, MIN_COUNT_ORDER);
        cls_mask = (sh >= WORD_ORDER) ? '1 : WORD_W'((1 << (1 << sh)) - 1);
        last_row = (row_r == RW'(row_base(c, MIN_BLOCK_ORDER, REGION_ORDER, MIN_COUNT_ORDER)
                              + cls_rows(c, MIN_BLOCK_ORDER, REGION_ORDER,
                                         MIN_COUNT_ORDER) - 1));
        hit_addr = 32'(byte_base(c, MIN_BLOCK_ORDER, REGION_ORDER, MIN_COUNT_ORDER))
                 + ((((32'(row_r)
                      - 32'(row_base(c, MIN_BLOCK_ORDER, REGION_ORDER, MIN_COUNT_ORDER)))
                     << WORD_ORDER) + 32'(hit_bit)) << (MIN_BLOCK_ORDER + c));
      end
    end
  end

  // lowest free block in the current row
  always_comb begin
    masked  = rdata_r & cls_mask;
    hit_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (masked[b]) hit_bit = BIT_W'(b);
    end
  end

  assign scan_hit   = |masked;
  assign last_cls   = (cls_r == CLS_W'(NUM_CLASSES - 1));
  assign clear_done = (row_r == RW'(NUM_ROWS - 1));

  // next row and class
  always_comb begin
    row_nxt = row_r;
    cls_nxt = cls_r;
    priority if (cmd.clear_wr) begin
      row_nxt = clear_done ? '0 : RW'(row_r + 1'b1);
    end else if (cmd.decode) begin
      row_nxt = (cmd_r == CMD_FREE) ? free_row : fit_row;
      cls_nxt = fit_cls;
    end else if (cmd.scan && !scan_hit && !(last_row && last_cls)) begin
      row_nxt = RW'(row_r + 1'b1);
      if (last_row) cls_nxt = CLS_W'(cls_r + 1'b1);
    end
  end

  // free map write port
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = rdata_r;
    priority if (cmd.clear_wr) begin
      mem_we    = 1'b1;
      mem_wdata = '1;
    end else if (cmd.scan && scan_hit) begin
      mem_we    = 1'b1;
      mem_wdata = rdata_r & ~(WORD_W'(1) << hit_bit);
    end else if (cmd.fset) begin
      mem_we    = 1'b1;
      mem_wdata = rdata_r | (WORD_W'(1) << bit_r);
    end
  end

  // memory with registered read of the next row
  always_ff @(posedge clk) begin
    if (mem_we) mem[row_r] <= mem_wdata;
    rdata_r <= mem[row_nxt];
  end

  // scan position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      cls_r <= '0;
    end else begin
      row_r <= row_nxt;
      cls_r <= cls_nxt;
    end
  end

  // request capture, result and output register
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      cmd_r   <= in_cmd;
      req_r   <= in_req_size;
      faddr_r <= in_free_addr;
    end
    if (cmd.decode) begin
      bit_r      <= free_bit;
      res_addr_r <= '0;
      if (cmd_r == CMD_FREE) begin
        res_status_r <= free_bad ? STAT_BADADDR : STAT_OK;
      end else begin
        res_status_r <= STAT_NOFIT;
      end
    end
    if (cmd.scan && scan_hit) begin
      res_addr_r   <= hit_addr[ADDR_W-1:0];
      res_status_r <= STAT_OK;
    end
    if (cmd.load_out) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
    end
  end

  assign stat.cmd_free   = (cmd_r == CMD_FREE);
  assign stat.fit_none   = fit_none;
  assign stat.free_bad   = free_bad;
  assign stat.scan_hit   = scan_hit;
  assign stat.scan_end   = last_row && last_cls;
  assign stat.clear_done = clear_done;

  assign out_block_addr = out_addr_r;
  assign out_status     = out_status_r;

endmodule
`default_nettype wire

// ===== rtl/size_class_block_allocator.sv =====
// top level of the size-class block allocator
//
// Pool allocator with power-of-two size classes. A request on the in_ channel
// is either an allocate (in_cmd 0, in_req_size bytes) or a free (in_cmd 1,
// in_free_addr). Every request gives exactly one result on the out_ channel:
// out_block_addr (allocated address, zero otherwise) and out_status
// (ok, no fitting block, or invalid free address).
// Free blocks are tracked in a free map memory of 32-bit rows, one bit per
// block; each class starts on a row of its own (15 rows at default sizes).
// A valid free is decoded and then sets its bit in the map; an invalid free
// or an oversize allocate goes from decode straight to the result, and any
// other allocate scans the map row by row, from the first row of the fitting
// class up to the row that holds a free block (up to 15 rows at default
// sizes). One request is in flight at a time and the next is taken as its
// predecessor's result appears, so a new request cannot start before then.
// After reset the map is set to all free by a pass of one row per cycle
// (15 rows at default sizes); in_ready stays low until it ends.
// A result waits in the output register while out_ready is low; the next
// request is accepted meanwhile and holds its result until the register frees.
`default_nettype none
module size_class_block_allocator #(
  parameter int NUM_CLASSES     = scba_pkg::DEF_NUM_CLASSES,
  parameter int MIN_BLOCK_ORDER = scba_pkg::DEF_MIN_BLOCK_ORDER,
  parameter int REGION_ORDER    = scba_pkg::DEF_REGION_ORDER,
  parameter int MIN_COUNT_ORDER = scba_pkg::DEF_MIN_COUNT_ORDER
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [scba_pkg::CMD_W-1:0]        in_cmd,
  input  wire  [scba_pkg::SIZE_W-1:0]       in_req_size,
  input  wire  [scba_pkg::ADDR_W-1:0]       in_free_addr,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [scba_pkg::ADDR_W-1:0]       out_block_addr,
  output logic [scba_pkg::STATUS_W-1:0]     out_status
);
  import scba_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencing of each request
  scba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // free map and address arithmetic
  scba_dp #(
    .NUM_CLASSES     (NUM_CLASSES),
    .MIN_BLOCK_ORDER (MIN_BLOCK_ORDER),
    .REGION_ORDER    (REGION_ORDER),
    .MIN_COUNT_ORDER (MIN_COUNT_ORDER)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_cmd         (in_cmd),
    .in_req_size    (in_req_size),
    .in_free_addr   (in_free_addr),
    .out_block_addr (out_block_addr),
    .out_status     (out_status),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule
`default_nettype wire
